// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define HHP_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HHP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hhp_pkg.sv
package hhp_pkg;

   localparam int DIVISOR_W = 16;

   // Mode codes.
   localparam logic signed [2:0] MODE_PASS   = -3'sd1;
   localparam logic signed [2:0] MODE_CONT   = 3'sd0;
   localparam logic signed [2:0] MODE_STEP45 = 3'sd1;
   localparam logic signed [2:0] MODE_STEP90 = 3'sd2;

   // Register reset values.
   localparam logic [7:0]  CFG_PROP_GAIN_RST  = 8'd1;
   localparam logic [15:0] CFG_INTEG_DIV_RST  = 16'd100;
   localparam logic [7:0]  CFG_DERIV_GAIN_RST = 8'd0;
   localparam logic [6:0]  CFG_SCALE_RST      = 7'd10;
   localparam logic [15:0] CFG_TIMEOUT_RST    = 16'd1000;
   localparam logic [6:0]  CFG_TRIGGER_RST    = 7'd64;

   localparam logic [6:0]  SCALE_MAX     = 7'd64;
   localparam int          HALF_TURN_DEG = 180;
   localparam int          DRIVE_LIMIT   = 127;

   localparam logic signed [10:0] HALF_TURN_W = 11'sd180;
   localparam logic signed [10:0] FULL_TURN_W = 11'sd360;
   localparam logic signed [8:0]  ERR_HALF    = 9'sd180;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN,
      CSR_INTEG_DIVISOR,
      CSR_DERIV_GAIN,
      CSR_SETPOINT_SCALE,
      CSR_TIMEOUT_TICKS,
      CSR_TRIGGER_LEVEL
   } hhp_csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_PASS_WRAP,
      ST_PASS_MUL,
      ST_SP_START,
      ST_SP_WAIT,
      ST_Q_START,
      ST_Q_WAIT,
      ST_ERR_NORM1,
      ST_ERR_NORM2,
      ST_P_MUL,
      ST_D_MUL,
      ST_I_WAIT,
      ST_OUT
   } hhp_state_type;

   // Effective configuration as seen by the controller.
   typedef struct packed {
      logic [7:0]  prop_gain;
      logic [15:0] integ_divisor;
      logic [7:0]  deriv_gain;
      logic [6:0]  scale;
      logic [13:0] half_span;
      logic [15:0] timeout_ticks;
      logic [6:0]  trigger_level;
   } hhp_cfg_type;

   // One wrap step toward [-180, 180).
   function automatic logic signed [10:0] norm180(input logic signed [10:0] v);
      logic signed [10:0] r;
      if (v >= HALF_TURN_W) begin
         r = v - FULL_TURN_W;
      end else if (v < -HALF_TURN_W) begin
         r = v + FULL_TURN_W;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: design/hhp_if.sv
interface hhp_req_if;
   logic              valid;
   logic              ready;
   logic              button_less;
   logic              button_more;
   logic signed [7:0] yaw_command;
   logic signed [7:0] forward_command;
   logic signed [7:0] lateral_command;
   logic signed [8:0] heading_deg;
   logic signed [8:0] pan_deg;

   modport source (
      output valid, button_less, button_more, yaw_command, forward_command,
             lateral_command, heading_deg, pan_deg,
      input  ready
   );
   modport sink (
      input  valid, button_less, button_more, yaw_command, forward_command,
             lateral_command, heading_deg, pan_deg,
      output ready
   );
endinterface

interface hhp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [7:0]  drive_yaw;
   logic signed [2:0]  mode;
   logic signed [14:0] target_heading;

   modport source (
      output valid, drive_yaw, mode, target_heading,
      input  ready
   );
   modport sink (
      input  valid, drive_yaw, mode, target_heading,
      output ready
   );
endinterface

// File: design/heading_hold_pid.sv
// Channel    Direction  Handshake             Carries
// req_chan   in         valid / ready         buttons, yaw, forward, lateral, heading, pan
// rsp_chan   out        valid / ready         drive_yaw, mode, target_heading
// csr_*      in         write enable only     six registers, 3-bit index, 16-bit data
//
// A control tick goes from transfer to result register via ST_START and ST_OUT when
// the timeout has expired, adds the wrap and multiply states in passthrough mode and
// runs the PID states otherwise; the serial divider takes max(INTEG_WIDTH, 17) steps.
// The divider is used three times per PID tick (set-point wrap, set point over scale,
// integrator over divisor); one shared multiplier serves the gain and scale products.
// Reset is synchronous and active high; it restores the register defaults and state.
// req_chan.ready is high only while the sequencer is idle. A finished result waits in
// the output register while the next transfer is taken; a stalled output only holds
// the sequencer in its final state until the register frees up.
`include "assert_macros.svh"

module heading_hold_pid import hhp_pkg::*; #(
   parameter int INTEG_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   hhp_req_if.sink     req_chan,
   hhp_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Divider dividend must hold the integrator and the set point plus half a turn.
   localparam int DIV_W = (INTEG_WIDTH > 17) ? INTEG_WIDTH : 17;
   // Accumulated drive: products below 2^18 plus the integrator quotient.
   localparam int SUM_W = DIV_W + 2;
   localparam logic signed [SUM_W-1:0] DRV_HI = SUM_W'(DRIVE_LIMIT);
   localparam logic signed [SUM_W-1:0] DRV_LO = -SUM_W'(DRIVE_LIMIT);

   hhp_cfg_type cfg;

   // Controller state that survives from tick to tick.
   hhp_state_type                  state_ff, state_in;
   logic signed [2:0]              mode_ff, mode_in;
   logic                           prev_less_ff, prev_less_in;
   logic                           prev_more_ff, prev_more_in;
   logic signed [8:0]              prev_pan_ff, prev_pan_in;
   logic [15:0]                    idle_ff, idle_in;
   logic signed [14:0]             setpoint_ff, setpoint_in;
   logic signed [INTEG_WIDTH-1:0]  integ_ff, integ_in;
   logic signed [8:0]              prev_err_ff, prev_err_in;
   logic signed [7:0]              prev_yaw_ff, prev_yaw_in;

   // Captured request and working registers.
   logic signed [7:0]              yaw_ff, yaw_in;
   logic signed [8:0]              heading_ff, heading_in;
   logic signed [8:0]              pan_ff, pan_in;
   logic                           motion_ff, motion_in;
   logic signed [16:0]             acc_ff, acc_in;
   logic signed [10:0]             err_ff, err_in;
   logic signed [9:0]              deriv_ff, deriv_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [7:0]              drive_ff, drive_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]              rsp_drive_ff, rsp_drive_in;
   logic signed [2:0]              rsp_mode_ff, rsp_mode_in;
   logic signed [14:0]             rsp_target_ff, rsp_target_in;

   // Shared divider.
   logic                           div_start;
   logic signed [DIV_W-1:0]        div_dividend;
   logic [DIVISOR_W-1:0]           div_divisor;
   logic                           div_done;
   logic signed [DIV_W-1:0]        div_quot;
   logic signed [DIVISOR_W:0]      div_rem;

   // Shared multiplier.
   logic signed [9:0]              mul_a;
   logic [7:0]                     mul_b;
   logic signed [18:0]             prod;

   // Datapath helpers.
   logic                           active;
   logic [15:0]                    idle_load;
   logic signed [8:0]              yaw_w, prev_yaw_w, trig_w;
   logic                           trig_up, trig_down;
   logic [13:0]                    step_amt;
   logic signed [16:0]             step_w, delta;
   logic signed [16:0]             half_w;
   logic signed [16:0]             sp_dividend;
   logic signed [16:0]             sp_wrapped;
   logic signed [10:0]             err_q;
   logic signed [10:0]             err_norm;
   logic signed [8:0]              err9;
   logic signed [INTEG_WIDTH:0]    integ_sum;
   logic signed [INTEG_WIDTH-1:0]  integ_sat;
   logic                           zero_cross;
   logic signed [SUM_W-1:0]        total;
   logic signed [7:0]              drive_clamped;
   logic signed [14:0]             half_s;

   hhp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hhp_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign prod = 19'(mul_a) * 19'($signed({1'b0, mul_b}));

   // Any stick motion or pan change reloads the inactivity timeout.
   assign active    = (pan_ff != prev_pan_ff) || motion_ff || (yaw_ff != 8'sd0);
   assign idle_load = active ? cfg.timeout_ticks : idle_ff;

   // Trigger edges for the step modes.
   assign yaw_w      = 9'(yaw_ff);
   assign prev_yaw_w = 9'(prev_yaw_ff);
   assign trig_w     = $signed({2'b00, cfg.trigger_level});
   assign trig_up    = (yaw_w >= trig_w) && (prev_yaw_w < trig_w);
   assign trig_down  = (yaw_w <= -trig_w) && (prev_yaw_w > -trig_w);

   // 45 and 90 degree steps are a quarter and a half of the half-turn span.
   assign step_amt = (mode_ff == MODE_STEP45) ? (cfg.half_span >> 2) : (cfg.half_span >> 1);
   assign step_w   = $signed({3'b000, step_amt});

   always_comb begin
      if (mode_ff == MODE_CONT) begin
         delta = 17'(yaw_ff);
      end else if (trig_up) begin
         delta = step_w;
      end else if (trig_down) begin
         delta = -step_w;
      end else begin
         delta = 17'sd0;
      end
   end

   // Set-point wrap: remainder of (sp + half) by the full span, shifted back by half.
   assign half_w      = $signed({3'b000, cfg.half_span});
   assign sp_dividend = acc_ff + half_w;
   assign sp_wrapped  = div_rem[DIVISOR_W] ? (div_rem + half_w) : (div_rem - half_w);
   assign half_s      = $signed({1'b0, cfg.half_span});

   assign err_q    = $signed(div_quot[10:0]) - 11'(heading_ff) - 11'(pan_ff);
   assign err_norm = norm180(err_ff);
   assign err9     = err_norm[8:0];

   // Integrator saturates to its width and clears when the error reaches or crosses zero.
   assign integ_sum = (INTEG_WIDTH + 1)'(integ_ff) + (INTEG_WIDTH + 1)'(err9);
   always_comb begin
      if (integ_sum[INTEG_WIDTH] != integ_sum[INTEG_WIDTH-1]) begin
         integ_sat = integ_sum[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH - 1){1'b0}}}
                                            : {1'b0, {(INTEG_WIDTH - 1){1'b1}}};
      end else begin
         integ_sat = integ_sum[INTEG_WIDTH-1:0];
      end
   end
   assign zero_cross = ((err9 >= 0) && (prev_err_ff < 0)) || ((err9 <= 0) && (prev_err_ff > 0));

   assign total = sum_ff + SUM_W'(div_quot);
   assign drive_clamped = (total > DRV_HI) ? 8'(DRIVE_LIMIT) :
                          (total < DRV_LO) ? -8'(DRIVE_LIMIT) : total[7:0];

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Sequencer: next state, register next values and shared-unit operand selection.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      prev_less_in  = prev_less_ff;
      prev_more_in  = prev_more_ff;
      prev_pan_in   = prev_pan_ff;
      idle_in       = idle_ff;
      setpoint_in   = setpoint_ff;
      integ_in      = integ_ff;
      prev_err_in   = prev_err_ff;
      prev_yaw_in   = prev_yaw_ff;
      yaw_in        = yaw_ff;
      heading_in    = heading_ff;
      pan_in        = pan_ff;
      motion_in     = motion_ff;
      acc_in        = acc_ff;
      err_in        = err_ff;
      deriv_in      = deriv_ff;
      sum_in        = sum_ff;
      drive_in      = drive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_drive_in  = rsp_drive_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_target_in = rsp_target_ff;
      div_start     = 1'b0;
      div_dividend  = DIV_W'(integ_ff);
      div_divisor   = cfg.integ_divisor;
      mul_a         = err_ff[9:0];
      mul_b         = cfg.prop_gain;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               // A "more" release wins over a "less" release in the same tick.
               if (!req_chan.button_more && prev_more_ff) begin
                  mode_in = (mode_ff < MODE_STEP90) ? (mode_ff + 3'sd1) : MODE_PASS;
               end else if (!req_chan.button_less && prev_less_ff) begin
                  mode_in = (mode_ff > MODE_PASS) ? (mode_ff - 3'sd1) : MODE_STEP90;
               end
               prev_less_in = req_chan.button_less;
               prev_more_in = req_chan.button_more;
               yaw_in       = req_chan.yaw_command;
               heading_in   = req_chan.heading_deg;
               pan_in       = req_chan.pan_deg;
               motion_in    = (req_chan.forward_command != 8'sd0) ||
                              (req_chan.lateral_command != 8'sd0);
               state_in     = ST_START;
            end
         end
         ST_START: begin
            if (mode_ff == MODE_PASS) begin
               // Passthrough latches the set point to pan plus heading.
               err_in      = 11'(pan_ff) + 11'(heading_ff);
               integ_in    = '0;
               prev_err_in = 9'sd0;
               drive_in    = yaw_ff;
               state_in    = ST_PASS_WRAP;
            end else begin
               prev_pan_in = pan_ff;
               if (idle_load == 16'd0) begin
                  idle_in     = idle_load;
                  integ_in    = '0;
                  prev_err_in = 9'sd0;
                  drive_in    = 8'sd0;
                  state_in    = ST_OUT;
               end else begin
                  idle_in     = idle_load - 16'd1;
                  prev_yaw_in = yaw_ff;
                  acc_in      = 17'(setpoint_ff) + delta;
                  state_in    = ST_SP_START;
               end
            end
         end
         ST_PASS_WRAP: begin
            err_in   = err_norm;
            state_in = ST_PASS_MUL;
         end
         ST_PASS_MUL: begin
            mul_a       = err_ff[9:0];
            mul_b       = {1'b0, cfg.scale};
            setpoint_in = prod[14:0];
            state_in    = ST_OUT;
         end
         ST_SP_START: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sp_dividend);
            div_divisor  = DIVISOR_W'({cfg.half_span, 1'b0});
            state_in     = ST_SP_WAIT;
         end
         ST_SP_WAIT: begin
            if (div_done) begin
               setpoint_in = sp_wrapped[14:0];
               state_in    = ST_Q_START;
            end
         end
         ST_Q_START: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(setpoint_ff);
            div_divisor  = DIVISOR_W'(cfg.scale);
            state_in     = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (div_done) begin
               err_in   = err_q;
               state_in = ST_ERR_NORM1;
            end
         end
         ST_ERR_NORM1: begin
            err_in   = err_norm;
            state_in = ST_ERR_NORM2;
         end
         ST_ERR_NORM2: begin
            err_in      = err_norm;
            integ_in    = zero_cross ? '0 : integ_sat;
            deriv_in    = 10'(err9) - 10'(prev_err_ff);
            prev_err_in = err9;
            state_in    = ST_P_MUL;
         end
         ST_P_MUL: begin
            mul_a    = err_ff[9:0];
            mul_b    = cfg.prop_gain;
            sum_in   = SUM_W'(prod);
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            mul_a        = deriv_ff;
            mul_b        = cfg.deriv_gain;
            sum_in       = sum_ff + SUM_W'(prod);
            div_start    = 1'b1;
            div_dividend = DIV_W'(integ_ff);
            div_divisor  = cfg.integ_divisor;
            state_in     = ST_I_WAIT;
         end
         ST_I_WAIT: begin
            if (div_done) begin
               drive_in = drive_clamped;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_drive_in  = drive_ff;
               rsp_mode_in   = mode_ff;
               rsp_target_in = setpoint_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PASS;
         prev_less_ff <= 1'b0;
         prev_more_ff <= 1'b0;
         prev_pan_ff  <= 9'sd0;
         idle_ff      <= CFG_TIMEOUT_RST;
         setpoint_ff  <= 15'sd0;
         integ_ff     <= '0;
         prev_err_ff  <= 9'sd0;
         prev_yaw_ff  <= 8'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         prev_less_ff <= prev_less_in;
         prev_more_ff <= prev_more_in;
         prev_pan_ff  <= prev_pan_in;
         idle_ff      <= idle_in;
         setpoint_ff  <= setpoint_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         prev_yaw_ff  <= prev_yaw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      yaw_ff        <= yaw_in;
      heading_ff    <= heading_in;
      pan_ff        <= pan_in;
      motion_ff     <= motion_in;
      acc_ff        <= acc_in;
      err_ff        <= err_in;
      deriv_ff      <= deriv_in;
      sum_ff        <= sum_in;
      drive_ff      <= drive_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_target_ff <= rsp_target_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drive_yaw      = rsp_drive_ff;
   assign rsp_chan.mode           = rsp_mode_ff;
   assign rsp_chan.target_heading = rsp_target_ff;

   // The mode register only ever cycles through its four codes.
   `HHP_ASSERT_ALWAYS(a_mode_range, clock, reset, (mode_ff >= MODE_PASS) && (mode_ff <= MODE_STEP90), "mode register left its range")

   // After the wrap divide the set point lies within half a turn of zero.
   `HHP_ASSERT_NEXT(a_sp_wrapped, clock, reset, (state_ff == ST_SP_WAIT) && div_done, (setpoint_ff >= -half_s) && (setpoint_ff < half_s), "set point not wrapped")

   // The stored error is always a wrapped angle.
   `HHP_ASSERT_NEXT(a_err_wrapped, clock, reset, state_ff == ST_ERR_NORM2, (prev_err_ff >= -ERR_HALF) && (prev_err_ff < ERR_HALF), "error not wrapped")

   // Outside passthrough the drive is clamped symmetrically and never reaches -128.
   `HHP_ASSERT_IMPLY(a_drive_clamp, clock, reset, rsp_valid_ff && (rsp_mode_ff != MODE_PASS), rsp_drive_ff != -8'sd128, "drive outside clamp")

endmodule

// File: design/hhp_csr.sv
module hhp_csr import hhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output hhp_cfg_type cfg
);

   logic [7:0]  prop_gain_ff;
   logic [15:0] integ_div_ff;
   logic [7:0]  deriv_gain_ff;
   logic [6:0]  scale_ff;
   logic [15:0] timeout_ff;
   logic [6:0]  trigger_ff;
   logic [6:0]  scale_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= CFG_PROP_GAIN_RST;
         integ_div_ff  <= CFG_INTEG_DIV_RST;
         deriv_gain_ff <= CFG_DERIV_GAIN_RST;
         scale_ff      <= CFG_SCALE_RST;
         timeout_ff    <= CFG_TIMEOUT_RST;
         trigger_ff    <= CFG_TRIGGER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROP_GAIN: begin
               prop_gain_ff <= csr_wdata[7:0];
            end
            CSR_INTEG_DIVISOR: begin
               integ_div_ff <= csr_wdata;
            end
            CSR_DERIV_GAIN: begin
               deriv_gain_ff <= csr_wdata[7:0];
            end
            CSR_SETPOINT_SCALE: begin
               scale_ff <= csr_wdata[6:0];
            end
            CSR_TIMEOUT_TICKS: begin
               timeout_ff <= csr_wdata;
            end
            CSR_TRIGGER_LEVEL: begin
               trigger_ff <= csr_wdata[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A scale of zero acts as one, and anything above the maximum is clipped.
   assign scale_eff = (scale_ff == 7'd0) ? 7'd1 :
                      (scale_ff > SCALE_MAX) ? SCALE_MAX : scale_ff;

   assign cfg.prop_gain     = prop_gain_ff;
   assign cfg.integ_divisor = (integ_div_ff == 16'd0) ? 16'd1 : integ_div_ff;
   assign cfg.deriv_gain    = deriv_gain_ff;
   assign cfg.scale         = scale_eff;
   assign cfg.half_span     = 14'(scale_eff) * 14'(HALF_TURN_DEG);
   assign cfg.timeout_ticks = timeout_ff;
   assign cfg.trigger_level = trigger_ff;

endmodule

// File: design/hhp_div.sv
module hhp_div import hhp_pkg::*; #(
   parameter int DIVIDEND_W = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output logic                         done,
   output logic signed [DIVIDEND_W-1:0] quotient,
   output logic signed [DIVISOR_W:0]    remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVISOR_W:0]    rem_ext;

   // Restoring division on magnitudes, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         neg_in  = dividend[DIVIDEND_W-1];
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Quotient truncates toward zero; the remainder takes the dividend's sign.
   assign rem_ext   = {1'b0, rem_ff};
   assign done      = done_ff;
   assign quotient  = $signed(neg_ff ? (~quo_ff + 1'b1) : quo_ff);
   assign remainder = $signed(neg_ff ? (~rem_ext + 1'b1) : rem_ext);

endmodule
